>>> src/tld_pkg.sv
package tld_pkg;

    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int KIND_W  = 2;
    localparam int TAPS_W  = 6;
    localparam int NOW_W   = 32;

    localparam logic [CFG_W-1:0] LONG_TOUCH_RST = 32'd2000;
    localparam logic [CFG_W-1:0] TAP_GAP_RST    = 32'd500;

    // register index, taken from paddr[2]
    localparam logic REG_LONG_TOUCH = 1'b0;
    localparam logic REG_TAP_GAP    = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 2'd0,
        KIND_TAPS = 2'd1,
        KIND_LONG = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] hold_limit_ms;
        logic [CFG_W-1:0] gap_limit_ms;
    } t_cfg;

endpackage

>>> src/tld_if.sv
interface tld_in_if
    import tld_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             touch_level;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, output touch_level, output now_ms, input ready);
    modport sink   (input valid, input touch_level, input now_ms, output ready);
endinterface

interface tld_out_if
    import tld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] gesture_kind;
    logic [TAPS_W-1:0] tap_total;

    modport source (output valid, output gesture_kind, output tap_total, input ready);
    modport sink   (input valid, input gesture_kind, input tap_total, output ready);
endinterface

>>> src/touch_tap_long_press_detector.sv
// Touch tap and long-press detector. Each request on i_in is one sensor poll (level and
// millisecond time) and yields exactly one result on o_out: nothing, a finished tap
// sequence with its count, or a long touch. A poll is held in an input register, then
// the gap and hold compares and the state update run combinationally into the result
// register; a new poll is taken every cycle unless o_out stalls with a result held. The
// only loop is the state feedback around that single stage. Timing registers sit on
// the APB port: hold limit at 0x0 (reset 2000), tap gap limit at 0x4 (reset 500).
// Write them only while no poll is in flight.
module touch_tap_long_press_detector
    import tld_pkg::*;
#(
    parameter int TAP_COUNT_MAX = 63,
    parameter int TIME_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tld_in_if.sink            i_in,
    tld_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);
    t_cfg cfg;

    tld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tld_core #(
        .TAP_COUNT_MAX (TAP_COUNT_MAX),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // a tap count only travels with a tap report
    a_taps_only_with_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.tap_total == '0 || o_out.gesture_kind == KIND_TAPS))
        else $error("tap count on a non-tap result");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid straight after reset");

    // a register written reads back on the next cycle
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2]))
        |-> (prdata == $past(pwdata)))
        else $error("register readback mismatch");
endmodule

>>> src/tld_cfg.sv
module tld_cfg
    import tld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    logic [CFG_W-1:0] r_long_touch;
    logic [CFG_W-1:0] r_tap_gap;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_touch <= LONG_TOUCH_RST;
            r_tap_gap    <= TAP_GAP_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_LONG_TOUCH: r_long_touch <= pwdata;
                REG_TAP_GAP:    r_tap_gap    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LONG_TOUCH: prdata = r_long_touch;
            REG_TAP_GAP:    prdata = r_tap_gap;
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.hold_limit_ms = r_long_touch;
    assign o_cfg.gap_limit_ms  = r_tap_gap;
endmodule

>>> src/tld_core.sv
module tld_core
    import tld_pkg::*;
#(
    parameter int TAP_COUNT_MAX = 63,
    parameter int TIME_WIDTH    = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    tld_in_if.sink    i_in,
    tld_out_if.source o_out
);
    localparam int PW = $clog2(TAP_COUNT_MAX + 1);
    localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam int TW = (PW > TAPS_W) ? PW : TAPS_W;

    // input register
    logic                  r_in_valid;
    logic                  r_in_level;
    logic [NOW_W-1:0]      r_in_now;

    // detector state
    logic [TIME_WIDTH-1:0] r_last;
    logic [TIME_WIDTH-1:0] r_start;
    logic [PW-1:0]         r_pend;
    logic                  r_held;
    logic                  r_long;
    logic [TIME_WIDTH-1:0] n_last;
    logic [TIME_WIDTH-1:0] n_start;
    logic [PW-1:0]         n_pend;
    logic                  n_held;
    logic                  n_long;

    // result register
    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [TAPS_W-1:0]     r_out_taps;
    t_kind                 n_kind;
    logic [TAPS_W-1:0]     n_taps;

    logic                  adv;
    logic                  fire;
    logic [CW-1:0]         now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] gap_el;
    logic [TIME_WIDTH-1:0] hold_el;
    logic                  gap_over;
    logic                  hold_over;
    logic [PW-1:0]         pend_inc;

    assign adv        = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_level <= i_in.touch_level;
            r_in_now   <= i_in.now_ms;
        end
    end

    assign now_ext  = CW'(r_in_now);
    assign now_t    = now_ext[TIME_WIDTH-1:0];
    assign gap_el   = now_t - r_last;
    assign gap_over = CW'(gap_el) > CW'(i_cfg.gap_limit_ms);
    assign pend_inc = (r_pend == PW'(TAP_COUNT_MAX)) ? r_pend : r_pend + PW'(1);
    // hold time is taken from the start as updated by this poll
    assign hold_el   = now_t - n_start;
    assign hold_over = CW'(hold_el) >= CW'(i_cfg.hold_limit_ms);

    always_comb begin
        n_last  = r_last;
        n_start = r_start;
        n_pend  = r_pend;
        n_held  = r_held;
        n_long  = r_long;
        if (r_in_level && !r_held && !r_long) begin
            n_pend = pend_inc;
            n_last = now_t;
            if (pend_inc == PW'(1)) begin
                n_start = now_t;
            end
        end
        if (!r_in_level) begin
            n_held = 1'b0;
            if (r_long) begin
                n_long = 1'b0;
                n_pend = '0;
            end else if (r_pend != '0 && gap_over) begin
                n_pend = '0;
            end
        end else begin
            n_held = 1'b1;
            if (!r_long && hold_over) begin
                n_long = 1'b1;
                n_pend = '0;
            end
        end
    end

    always_comb begin
        logic [TW-1:0] pend_ext;
        pend_ext = TW'(r_pend);
        n_kind   = KIND_NONE;
        n_taps   = '0;
        if (!r_in_level) begin
            if (!r_long && r_pend != '0 && gap_over) begin
                n_kind = KIND_TAPS;
                n_taps = pend_ext[TAPS_W-1:0];
            end
        end else if (!r_long && hold_over) begin
            n_kind = KIND_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_start <= '0;
            r_pend  <= '0;
            r_held  <= 1'b0;
            r_long  <= 1'b0;
        end else if (fire) begin
            r_last  <= n_last;
            r_start <= n_start;
            r_pend  <= n_pend;
            r_held  <= n_held;
            r_long  <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind <= n_kind;
            r_out_taps <= n_taps;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.gesture_kind = r_out_kind;
    assign o_out.tap_total    = r_out_taps;
endmodule
